// File: src/tneg_pkg.sv
// Shared types and constants for the tool-name egress gate.
// Holds the deny lists, the own-server namespace bytes and the verdict types.
// No dependencies.
`timescale 1ns / 1ps

package tneg_pkg;

  localparam int unsigned WINDOW_BYTES_DEF   = 12;
  localparam int unsigned POSITION_LIMIT_DEF = 13;

  // Bytes of the window the matchers look at (longest substring entry)
  localparam int unsigned MATCH_SPAN = 12;
  localparam int unsigned TXT_W      = MATCH_SPAN * 8;
  localparam int unsigned HIST_W     = (MATCH_SPAN - 1) * 8;

  localparam int unsigned EXACT_COUNT  = 26;
  localparam int unsigned SUBSTR_COUNT = 12;
  localparam int unsigned PREFIX_COUNT = 3;

  localparam int unsigned SERVER_PREFIX_LEN = 5;
  localparam int unsigned OWN_NAME_LEN      = 10;
  localparam int unsigned OWN_SPACE_LEN     = 12;

  // Item kinds on the input tuser
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_EMPTY  = 2'd1;
  localparam logic [1:0] KIND_ABSENT = 2'd2;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_DECLARED  = 3'd1,
    CAUSE_THIRD     = 3'd2,
    CAUSE_EXACT     = 3'd3,
    CAUSE_SUBSTR    = 3'd4,
    CAUSE_DELIVERED = 3'd5,
    CAUSE_ABSENT    = 3'd6
  } cause_t;

  // Packs into out_tdata[4:0]: permitted lowest
  typedef struct packed {
    cause_t cause;
    logic   externalizing;
    logic   permitted;
  } verdict_t;

  typedef struct packed {
    logic [EXACT_COUNT-1:0]  exact_alive;
    logic [PREFIX_COUNT-1:0] prefix_alive;
    logic [SUBSTR_COUNT-1:0] sub_hits;
  } match_state_t;

  localparam match_state_t MATCH_CLEAR = '{
    exact_alive:  {EXACT_COUNT{1'b1}},
    prefix_alive: {PREFIX_COUNT{1'b1}},
    sub_hits:     '0
  };

  // Literals are right-justified: first character in the highest used byte
  localparam logic [TXT_W-1:0] EXACT_TXT [EXACT_COUNT] = '{
    "pr.open", "pr_open", {"propose", "_pr"}, "open_pr", "merge",
    "pr.merge", {"git", "_push"}, "git-push", "push", "gh_pr",
    {"web", "_fetch"}, "webfetch", "fetch", "http", {"http", "_request"},
    {"web", "_read"}, "webread", "curl", "wget", {"send", "_email"},
    "email", "notify", "notification", "slack", {"post", "_comment"},
    "comment"
  };

  localparam int unsigned EXACT_LEN [EXACT_COUNT] = '{
    7, 7, 10, 7, 5,
    8, 8, 8, 4, 5,
    9, 8, 5, 4, 12,
    8, 7, 4, 4, 10,
    5, 6, 12, 5, 12,
    7
  };

  // Right-justified, so the last character sits in byte 0 like the newest window byte
  localparam logic [TXT_W-1:0] SUB_TXT [SUBSTR_COUNT] = '{
    "push", {"create", "_pull"}, {"pull", "_request"}, "merge", "publish", "deploy",
    "release", "upload", "egress", "outbound", "webhook", "notify"
  };

  localparam int unsigned SUB_LEN [SUBSTR_COUNT] = '{
    4, 11, 12, 5, 7, 6,
    7, 6, 6, 8, 7, 6
  };

  // Own server namespace: prefix, server name, then a double underscore
  localparam logic [7:0] OWN_NS [OWN_SPACE_LEN] = '{
    8'h6d, 8'h63, 8'h70, 8'h5f, 8'h5f, 8'h61,
    8'h69, 8'h6d, 8'h65, 8'h65, 8'h5f, 8'h5f
  };

  localparam int unsigned PREFIX_LEN [PREFIX_COUNT] = '{
    SERVER_PREFIX_LEN, OWN_NAME_LEN, OWN_SPACE_LEN
  };

endpackage

// File: src/tool_name_egress_gate_core.sv
// Tool-name egress gate: top level with input stage, name state and verdict register.
// Verdict path from input transaction to out_tvalid: input reg, then result reg.
// One byte transaction per cycle unless stalled; all matching is a single combinational pass.
// A stalled verdict stalls the input only when the item in the input register ends a name.
// Reset (rst_n low, synchronous) empties both stages and returns the name state to empty.
// Depends on tneg_pkg and tneg_match.
`timescale 1ns / 1ps

module tool_name_egress_gate_core
  import tneg_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES   = WINDOW_BYTES_DEF,
  parameter int unsigned POSITION_LIMIT = POSITION_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] name_byte, [8] delivered, [9] declared_external
  input  logic [1:0]  in_tuser,   // [1:0] item_kind
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] permitted, [1] externalizing, [4:2] cause
);

  localparam int unsigned POS_W = $clog2(POSITION_LIMIT + 1);

  // Input stage
  logic       a_valid_r;
  logic [1:0] a_kind_r;
  logic [7:0] a_byte_r;
  logic       a_last_r;
  logic       a_deliv_r;
  logic       a_decl_r;

  // Name state
  logic [7:0]       window_r [WINDOW_BYTES];
  logic [POS_W-1:0] pos_r;
  match_state_t     st_r;

  // Result stage
  logic     out_valid_r;
  verdict_t out_data_r;

  logic             in_accept;
  logic             emit;        // input-stage item ends a name
  logic             out_free;
  logic             a_adv;       // input-stage item leaves this cycle
  logic [HIST_W-1:0] hist;
  logic [7:0]       low_byte;
  logic [POS_W-1:0] pos_nxt;
  match_state_t     st_nxt;
  cause_t           cls;
  verdict_t         res;

  assign emit      = (a_kind_r != KIND_BYTE) || a_last_r;
  assign out_free  = !out_valid_r || out_tready;
  assign a_adv     = a_valid_r && (!emit || out_free);
  assign in_tready = !a_valid_r || a_adv;
  assign in_accept = in_tvalid && in_tready;

  for (genvar k = 0; k < MATCH_SPAN - 1; k++) begin : gen_hist
    assign hist[k*8 +: 8] = window_r[k];
  end

  tneg_match #(
    .POSITION_LIMIT(POSITION_LIMIT)
  ) u_match (
    .raw_byte(a_byte_r),
    .pos     (pos_r),
    .hist    (hist),
    .st      (st_r),
    .declared(a_decl_r),
    .low_byte(low_byte),
    .pos_nxt (pos_nxt),
    .st_nxt  (st_nxt),
    .cls     (cls)
  );

  // Verdict; delivered overrides permission and cause but keeps the class
  always_comb begin
    res = '{cause: CAUSE_NONE, externalizing: 1'b0, permitted: 1'b1};
    unique case (a_kind_r)
      KIND_BYTE: begin
        res.permitted     = (cls == CAUSE_NONE);
        res.externalizing = (cls != CAUSE_NONE);
        res.cause         = cls;
      end
      KIND_EMPTY: begin
        res.permitted = 1'b1;
        res.cause     = CAUSE_NONE;
      end
      default: begin   // absent name, and the unused kind fails closed
        res.permitted = 1'b0;
        res.cause     = CAUSE_ABSENT;
      end
    endcase
    if (a_deliv_r) begin
      res.permitted = 1'b1;
      res.cause     = CAUSE_DELIVERED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_accept) begin
      a_valid_r <= 1'b1;
    end else if (a_adv) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_kind_r  <= in_tuser;
      a_byte_r  <= in_tdata[7:0];
      a_last_r  <= in_tlast;
      a_deliv_r <= in_tdata[8];
      a_decl_r  <= in_tdata[9];
    end
  end

  // Name state: advance on each byte, clear at every name end
  always_ff @(posedge clk) begin
    if (!rst_n || (a_adv && emit)) begin
      for (int k = 0; k < WINDOW_BYTES; k++) begin
        window_r[k] <= '0;
      end
      pos_r <= '0;
      st_r  <= MATCH_CLEAR;
    end else if (a_adv) begin
      for (int k = WINDOW_BYTES - 1; k > 0; k--) begin
        window_r[k] <= window_r[k-1];
      end
      window_r[0] <= low_byte;
      pos_r       <= pos_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && emit) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r};

endmodule

// File: src/tneg_match.sv
// Per-byte matching and classification for the egress gate.
// Lowercases one byte, advances the match masks and classifies the name.
// Depends on tneg_pkg.
`timescale 1ns / 1ps

module tneg_match
  import tneg_pkg::*;
#(
  parameter int unsigned POSITION_LIMIT = POSITION_LIMIT_DEF,
  localparam int unsigned POS_W = $clog2(POSITION_LIMIT + 1)
) (
  input  logic [7:0]       raw_byte,
  input  logic [POS_W-1:0] pos,
  input  logic [HIST_W-1:0] hist,     // window bytes 0.. older, byte 0 newest
  input  match_state_t     st,
  input  logic             declared,
  output logic [7:0]       low_byte,
  output logic [POS_W-1:0] pos_nxt,
  output match_state_t     st_nxt,
  output cause_t           cls
);

  logic [MATCH_SPAN-1:0]   pos_is;
  logic [MATCH_SPAN-1:0]   own_hit;
  logic                    own_at_pos;
  logic [TXT_W-1:0]        win;
  logic [EXACT_COUNT-1:0]  exact_nxt;
  logic [EXACT_COUNT-1:0]  exact_len_hit;
  logic [PREFIX_COUNT-1:0] pfx_nxt;
  logic [SUBSTR_COUNT-1:0] sub_nxt;
  logic                    third;

  assign low_byte = (raw_byte >= 8'h41 && raw_byte <= 8'h5a) ? raw_byte + 8'h20 : raw_byte;
  assign win      = {hist, low_byte};
  assign pos_nxt  = (pos < POS_W'(POSITION_LIMIT)) ? pos + POS_W'(1) : pos;

  for (genvar j = 0; j < MATCH_SPAN; j++) begin : gen_pos
    assign pos_is[j]  = (pos == POS_W'(j));
    assign own_hit[j] = (low_byte == OWN_NS[j]);
  end
  assign own_at_pos = |(own_hit & pos_is);

  // Exact list: an entry survives while each byte matches at its position
  for (genvar i = 0; i < EXACT_COUNT; i++) begin : gen_exact
    logic [MATCH_SPAN-1:0] hit;
    for (genvar j = 0; j < MATCH_SPAN; j++) begin : gen_chr
      if (j < EXACT_LEN[i]) begin : gen_in
        assign hit[j] = (low_byte == EXACT_TXT[i][(EXACT_LEN[i]-1-j)*8 +: 8]);
      end else begin : gen_out
        assign hit[j] = 1'b0;
      end
    end
    assign exact_nxt[i]     = st.exact_alive[i] & |(hit & pos_is);
    assign exact_len_hit[i] = exact_nxt[i] & (pos_nxt == POS_W'(EXACT_LEN[i]));
  end

  for (genvar i = 0; i < PREFIX_COUNT; i++) begin : gen_pfx
    assign pfx_nxt[i] = st.prefix_alive[i] & ((pos >= POS_W'(PREFIX_LEN[i])) | own_at_pos);
  end

  // Substrings: compare the newest N window bytes once N bytes of this name are in
  for (genvar i = 0; i < SUBSTR_COUNT; i++) begin : gen_sub
    localparam logic [TXT_W-1:0] MASK = {TXT_W{1'b1}} >> ((MATCH_SPAN - SUB_LEN[i]) * 8);
    assign sub_nxt[i] = st.sub_hits[i] |
                        (((win & MASK) == SUB_TXT[i]) && (pos >= POS_W'(SUB_LEN[i] - 1)));
  end

  assign st_nxt = '{exact_alive: exact_nxt, prefix_alive: pfx_nxt, sub_hits: sub_nxt};

  assign third = pfx_nxt[0] && (pos_nxt >= POS_W'(SERVER_PREFIX_LEN)) &&
                 !(pfx_nxt[1] && (pos_nxt == POS_W'(OWN_NAME_LEN))) &&
                 !(pfx_nxt[2] && (pos_nxt >= POS_W'(OWN_SPACE_LEN)));

  always_comb begin
    priority if (declared) begin
      cls = CAUSE_DECLARED;
    end else if (third) begin
      cls = CAUSE_THIRD;
    end else if (|exact_len_hit) begin
      cls = CAUSE_EXACT;
    end else if (|sub_nxt) begin
      cls = CAUSE_SUBSTR;
    end else begin
      cls = CAUSE_NONE;
    end
  end

endmodule

// File: src/tneg_chk.sv
// Port-level checker for the tool-name egress gate, bound to the top level.
// Checks reset, output hold under stall and consistency of verdict fields.
// Depends on tneg_pkg and tool_name_egress_gate_core.
`timescale 1ns / 1ps

module tneg_chk
  import tneg_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  logic       permitted;
  logic       externalizing;
  logic [2:0] cause;

  assign permitted     = out_tdata[0];
  assign externalizing = out_tdata[1];
  assign cause         = out_tdata[4:2];

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("verdict valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled verdict changed");

  a_deny_class: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && (cause == CAUSE_DECLARED || cause == CAUSE_THIRD ||
                     cause == CAUSE_EXACT || cause == CAUSE_SUBSTR)
      |-> !permitted && externalizing)
    else $error("classification cause without denial");

  a_absent: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && cause == CAUSE_ABSENT |-> !permitted && !externalizing)
    else $error("absent name verdict inconsistent");

  a_clean: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && (cause == CAUSE_NONE || cause == CAUSE_DELIVERED) |->
      permitted && (cause != CAUSE_NONE || !externalizing))
    else $error("permitting cause with inconsistent fields");

endmodule

bind tool_name_egress_gate_core tneg_chk u_tneg_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

// File: tb/tneg_verdict_checker.sv
`timescale 1ns / 1ps
// Verdict checker for the tool-name egress gate: watches both stream channels,
// keeps its own model of the name matchers and compares every verdict transaction.
// Depends on tneg_pkg for the item kinds and cause codes.

module tneg_verdict_checker
  import tneg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  output int          fail_count,
  output int          open_verdicts
);

  localparam int unsigned WIN     = 12;
  localparam int unsigned POS_MAX = 13;
  localparam int unsigned EXACT_N = 26;
  localparam int unsigned SUB_N   = 12;

  typedef struct packed {
    logic   permitted;
    logic   externalizing;
    cause_t cause;
  } gate_verdict_t;

  string exact_words [EXACT_N] = '{
    "pr.open", "pr_open", string'({"propose", "_pr"}), "open_pr", "merge", "pr.merge",
    string'({"git", "_push"}), "git-push", "push", "gh_pr", string'({"web", "_fetch"}),
    "webfetch", "fetch", "http", string'({"http", "_request"}), string'({"web", "_read"}),
    "webread", "curl", "wget", string'({"send", "_email"}), "email", "notify",
    "notification", "slack", string'({"post", "_comment"}), "comment"
  };

  string sub_words [SUB_N] = '{
    "push", string'({"create", "_pull"}), string'({"pull", "_request"}), "merge",
    "publish", "deploy", "release", "upload", "egress", "outbound", "webhook", "notify"
  };

  // server prefix, own server name, trailing double underscore
  localparam logic [7:0] NS_BYTES [12] = '{
    8'h6d, 8'h63, 8'h70, 8'h5f, 8'h5f, 8'h61,
    8'h69, 8'h6d, 8'h65, 8'h65, 8'h5f, 8'h5f
  };
  localparam int unsigned NS_LEN [3] = '{5, 10, 12};

  logic [7:0]         recent [WIN];   // newest byte at index 0
  logic [EXACT_N-1:0] exact_live;
  int unsigned        taken;
  logic [2:0]         ns_live;
  logic [SUB_N-1:0]   sub_seen;
  gate_verdict_t      verdicts_due [$];
  int                 fails;

  function automatic void clear_name();
    for (int i = 0; i < WIN; i++) recent[i] = 8'h00;
    exact_live = '1;
    taken      = 0;
    ns_live    = '1;
    sub_seen   = '0;
  endfunction

  function automatic void take_byte(input logic [7:0] raw);
    logic [7:0] c;
    int         n;
    bit         hit;
    c = (raw >= 8'h41 && raw <= 8'h5a) ? raw + 8'd32 : raw;
    for (int i = WIN - 1; i > 0; i--) recent[i] = recent[i - 1];
    recent[0] = c;
    for (int i = 0; i < EXACT_N; i++) begin
      n = exact_words[i].len();
      if (taken >= n || exact_words[i][taken] != c) exact_live[i] = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      if (taken < NS_LEN[i] && NS_BYTES[taken] != c) ns_live[i] = 1'b0;
    end
    for (int i = 0; i < SUB_N; i++) begin
      n = sub_words[i].len();
      if (taken + 1 >= n) begin
        hit = 1'b1;
        for (int j = 0; j < n; j++) begin
          if (recent[n - 1 - j] != sub_words[i][j]) hit = 1'b0;
        end
        if (hit) sub_seen[i] = 1'b1;
      end
    end
    if (taken < POS_MAX) taken++;
  endfunction

  // Order matters: declared, third-party server, exact list, substring list
  function automatic cause_t classify(input logic declared);
    bit third;
    if (declared) return CAUSE_DECLARED;
    third = ns_live[0] && taken >= NS_LEN[0];
    if (ns_live[1] && taken == NS_LEN[1]) third = 1'b0;
    if (ns_live[2] && taken >= NS_LEN[2]) third = 1'b0;
    if (third) return CAUSE_THIRD;
    for (int i = 0; i < EXACT_N; i++) begin
      if (exact_live[i] && exact_words[i].len() == taken) return CAUSE_EXACT;
    end
    if (sub_seen != '0) return CAUSE_SUBSTR;
    return CAUSE_NONE;
  endfunction

  always @(posedge clk) begin : watch
    gate_verdict_t got;
    gate_verdict_t want;
    cause_t        cls;
    bit            ends;
    if (!rst_n) begin
      clear_name();
      verdicts_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.permitted     = out_tdata[0];
        got.externalizing = out_tdata[1];
        got.cause         = cause_t'(out_tdata[4:2]);
        if (verdicts_due.size() == 0) begin
          $error("verdict transaction with none pending: tdata %b", out_tdata[4:0]);
          fails++;
        end else begin
          want = verdicts_due.pop_front();
          if (got.permitted !== want.permitted) begin
            $error("permitted: expected %0d, actual %0d", want.permitted, got.permitted);
            fails++;
          end
          if (got.externalizing !== want.externalizing) begin
            $error("externalizing: expected %0d, actual %0d",
                   want.externalizing, got.externalizing);
            fails++;
          end
          if (got.cause !== want.cause) begin
            $error("cause: expected %0d, actual %0d", want.cause, out_tdata[4:2]);
            fails++;
          end
        end
      end

      if (in_tvalid && in_tready) begin
        ends = 1'b1;
        cls  = CAUSE_NONE;
        case (in_tuser)
          KIND_BYTE: begin
            take_byte(in_tdata[7:0]);
            ends = in_tlast;
            if (ends) cls = classify(in_tdata[9]);
            want.permitted = (cls == CAUSE_NONE);
            want.cause     = cls;
          end
          KIND_EMPTY: begin
            want.permitted = 1'b1;
            want.cause     = CAUSE_NONE;
          end
          default: begin
            // absent name and the spare kind both fail closed
            want.permitted = 1'b0;
            want.cause     = CAUSE_ABSENT;
          end
        endcase
        if (ends) begin
          want.externalizing = (cls != CAUSE_NONE);
          if (in_tdata[8]) begin
            want.permitted = 1'b1;
            want.cause     = CAUSE_DELIVERED;
          end
          verdicts_due.push_back(want);
          clear_name();
        end
      end
    end
    fail_count    <= fails;
    open_verdicts <= verdicts_due.size();
  end

endmodule

// File: tb/tool_name_egress_gate_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for tool_name_egress_gate_core: stimulus, random back-pressure and verdict.
// Depends on tneg_pkg, the gate RTL and tneg_verdict_checker.

module tool_name_egress_gate_core_tb;
  import tneg_pkg::*;

  // Spare kind: the gate must treat it as an absent name
  localparam logic [1:0]  KIND_SPARE   = 2'd3;
  localparam int          RANDOM_ITEMS = 1650;
  localparam int unsigned MAX_GAP      = 18;
  localparam int unsigned WORD_COUNT   = 38;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] name_byte, [8] delivered, [9] declared_external
  logic [1:0]  in_tuser;   // [1:0] item_kind
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [0] permitted, [1] externalizing, [4:2] cause

  int          fail_count;
  int          open_verdicts;
  int          sent_items;
  bit          send_calm;
  bit          take_calm;
  logic [7:0]  name_buf [$];

  // Deny-list words plus a few names not on the lists, used as seeds for random names
  string words [WORD_COUNT] = '{
    "pr.open", "pr_open", string'({"propose", "_pr"}), "open_pr", "merge", "pr.merge",
    string'({"git", "_push"}), "git-push", "push", "gh_pr", string'({"web", "_fetch"}),
    "webfetch", "fetch", "http", string'({"http", "_request"}), string'({"web", "_read"}),
    "webread", "curl", "wget", string'({"send", "_email"}), "email", "notify",
    "notification", "slack", string'({"post", "_comment"}), "comment",
    string'({"create", "_pull"}), string'({"pull", "_request"}), "publish", "deploy",
    "release", "upload", "egress", "outbound", "webhook", "read_file",
    "list_dir", "pushy"
  };

  // Own namespace: server prefix, own server name, double underscore
  localparam logic [7:0] NS_TEXT [12] = '{
    8'h6d, 8'h63, 8'h70, 8'h5f, 8'h5f, 8'h61,
    8'h69, 8'h6d, 8'h65, 8'h65, 8'h5f, 8'h5f
  };

  tool_name_egress_gate_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tneg_verdict_checker verdict_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .open_verdicts (open_verdicts)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic bit coin(input int unsigned n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Calm stretches give back-to-back transactions; otherwise the idle gap before one is random
  function automatic int unsigned draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Lowercase letters flip to upper case now and then; the gate must fold them back
  function automatic logic [7:0] mixed_case(input logic [7:0] c, input bit vary);
    if (vary && c >= 8'h61 && c <= 8'h7a && coin(3)) return c - 8'd32;
    return c;
  endfunction

  task automatic add_text(input string s, input bit vary);
    for (int i = 0; i < s.len(); i++) name_buf.push_back(mixed_case(s[i], vary));
  endtask

  task automatic add_ns(input int n, input bit vary);
    for (int i = 0; i < n; i++) name_buf.push_back(mixed_case(NS_TEXT[i], vary));
  endtask

  // Half name-like characters, half any byte value
  task automatic add_noise(input int n);
    logic [7:0] v;
    for (int i = 0; i < n; i++) begin
      if (coin(2)) begin
        v = 8'($urandom_range(0, 26));
        v = (v == 8'd26) ? 8'h5f : 8'h61 + v;
        name_buf.push_back(mixed_case(v, 1'b1));
      end else begin
        name_buf.push_back(rand_byte());
      end
    end
  endtask

  // One input transaction. valid stays high straight into the next item when no gap
  // is drawn, so it only ever gets one nonblocking update per step.
  task automatic send_item(input logic [1:0] kind, input logic [7:0] data,
                           input logic last, input logic deliv, input logic decl);
    int unsigned gap;
    if (coin(40)) send_calm = !send_calm;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'b0, decl, deliv, data};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sent_items++;
  endtask

  // Sends name_buf, ended either by tlast on its final byte or by an end-kind item.
  // Flags on bytes before the end are don't-care, so they are randomised.
  task automatic send_name(input logic [1:0] end_kind, input logic deliv, input logic decl);
    int n;
    n = name_buf.size();
    for (int i = 0; i < n; i++) begin
      if (end_kind == KIND_BYTE && i == n - 1)
        send_item(KIND_BYTE, name_buf[i], 1'b1, deliv, decl);
      else
        send_item(KIND_BYTE, name_buf[i], 1'b0, coin(4), coin(4));
    end
    if (end_kind != KIND_BYTE) send_item(end_kind, rand_byte(), coin(2), deliv, decl);
    name_buf.delete();
  endtask

  // Hold the input off until every pending verdict has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (open_verdicts != 0);
  endtask

  task automatic make_and_send();
    int unsigned sel;
    int unsigned pos;
    logic [1:0]  end_kind;
    end_kind = KIND_BYTE;
    sel      = $urandom_range(0, 99);
    if (sel < 35) begin
      // listed word, sometimes buried inside a longer name
      if (coin(4)) add_noise($urandom_range(1, 3));
      add_text(words[$urandom_range(0, WORD_COUNT - 1)], 1'b1);
      if (coin(4)) add_noise($urandom_range(1, 4));
    end else if (sel < 52) begin
      // server prefix forms, own-server exemption and its near misses
      case ($urandom_range(0, 5))
        0: begin
          add_ns(5, 1'b1);
          if (coin(2)) add_text(words[$urandom_range(0, WORD_COUNT - 1)], 1'b1);
          else add_noise($urandom_range(0, 8));
        end
        1: add_ns(10, 1'b1);
        2: begin
          add_ns(12, 1'b1);
          add_noise($urandom_range(0, 6));
        end
        3: begin
          add_ns(11, 1'b1);
          if (coin(2)) add_noise(1);
        end
        4: add_ns($urandom_range(1, 11), 1'b1);
        default: begin
          add_ns(12, 1'b1);
          pos = $urandom_range(0, 11);
          name_buf[pos] = rand_byte();
          add_noise($urandom_range(0, 3));
        end
      endcase
    end else if (sel < 64) begin
      // listed word with one byte changed or the tail clipped
      add_text(words[$urandom_range(0, WORD_COUNT - 1)], 1'b1);
      pos = $urandom_range(0, name_buf.size() - 1);
      if (coin(2)) name_buf[pos] = rand_byte();
      else void'(name_buf.pop_back());
    end else if (sel < 86) begin
      add_noise($urandom_range(1, 20));
    end else begin
      // empty, absent or spare kind, possibly cutting a name short
      if (coin(2)) add_noise($urandom_range(1, 6));
      case ($urandom_range(0, 2))
        0:       end_kind = KIND_EMPTY;
        1:       end_kind = KIND_ABSENT;
        default: end_kind = KIND_SPARE;
      endcase
    end
    send_name(end_kind, coin(4), coin(5));
  endtask

  initial begin : stimulus
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= KIND_BYTE;
    in_tlast  <= 1'b0;
    rst_n     <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty name with declared set (ignored), absent, spare kind,
    // delivered absent name, delivered listed name in mixed case, top and bottom
    // byte values, a name ended early, third-party server, substring hit.
    send_name(KIND_EMPTY, 1'b0, 1'b1);
    send_name(KIND_ABSENT, 1'b0, 1'b0);
    send_name(KIND_SPARE, 1'b0, 1'b0);
    send_name(KIND_ABSENT, 1'b1, 1'b1);
    add_text("PuSh", 1'b0);
    send_name(KIND_BYTE, 1'b1, 1'b0);
    name_buf.push_back(8'hff);
    send_name(KIND_BYTE, 1'b0, 1'b1);
    name_buf.push_back(8'h00);
    send_name(KIND_BYTE, 1'b0, 1'b0);
    add_text("a", 1'b0);
    send_name(KIND_EMPTY, 1'b0, 1'b0);
    add_text("MCP__X", 1'b0);
    send_name(KIND_BYTE, 1'b0, 1'b0);
    add_text("deploy", 1'b0);
    send_name(KIND_BYTE, 1'b0, 1'b0);
    drain();

    // Random names, with the odd full drain between them
    while (sent_items < RANDOM_ITEMS + 24) begin
      make_and_send();
      if (coin(60)) drain();
    end
    drain();
    // two-stage pipeline: an idle wait here catches any stray verdict
    repeat (8) @(posedge clk);

    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls, one draw per verdict transaction
  initial begin : sink
    int unsigned gap;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (coin(40)) take_calm = !take_calm;
      gap = draw_gap(take_calm);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Time limit well beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
